@@ sv/tilt_compensated_heading_top_macros.svh @@
// Assertion macros shared by the tilt-compensated heading design.
`ifndef TILT_COMPENSATED_HEADING_TOP_MACROS_SVH
`define TILT_COMPENSATED_HEADING_TOP_MACROS_SVH

// Implication checked on the same clock edge, switched off while in reset.
`define THC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication whose consequence is checked after the delay given by dly, switched off while in reset.
`define THC_ASSERT_DLY(lbl, clk, rst_n, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##dly (cons)) \
        else $error("delayed check failed");

`endif

@@ sv/thc_pkg.sv @@
// Package with the shared types, constants and arctangent table of the heading block.
package thc_pkg;

    localparam int DW = 36;

    typedef logic signed [DW-1:0] t_data;

    localparam t_data ANG_HALF    = t_data'(64'sd2147483648);
    localparam t_data ANG_QUARTER = t_data'(64'sd1073741824);

    localparam logic signed [30:0] INV_GAIN = 31'sd652032874;

    // atan(2^-i) in binary angle units, one full turn being 2^32.
    function automatic t_data atan_tab(input int idx);
        t_data v;
        case (idx)
            0:       v = t_data'(64'sd536870912);
            1:       v = t_data'(64'sd316933406);
            2:       v = t_data'(64'sd167458907);
            3:       v = t_data'(64'sd85004756);
            4:       v = t_data'(64'sd42667331);
            5:       v = t_data'(64'sd21354465);
            6:       v = t_data'(64'sd10680862);
            7:       v = t_data'(64'sd5340245);
            8:       v = t_data'(64'sd2670163);
            9:       v = t_data'(64'sd1335087);
            10:      v = t_data'(64'sd667544);
            11:      v = t_data'(64'sd333772);
            12:      v = t_data'(64'sd166886);
            13:      v = t_data'(64'sd83443);
            14:      v = t_data'(64'sd41722);
            15:      v = t_data'(64'sd20861);
            16:      v = t_data'(64'sd10430);
            17:      v = t_data'(64'sd5215);
            18:      v = t_data'(64'sd2608);
            19:      v = t_data'(64'sd1304);
            20:      v = t_data'(64'sd652);
            21:      v = t_data'(64'sd326);
            22:      v = t_data'(64'sd163);
            23:      v = t_data'(64'sd81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/thc_cordic.sv @@
// Pipelined CORDIC, vectoring or rotating, one register stage per iteration.
module thc_cordic #(
    parameter int STAGES = 16,
    parameter int SW     = 1,
    parameter bit VEC    = 1'b1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  thc_pkg::t_data i_x,
    input  thc_pkg::t_data i_y,
    input  thc_pkg::t_data i_z,
    input  logic [SW-1:0]  i_side,
    output logic           o_valid,
    output thc_pkg::t_data o_x,
    output thc_pkg::t_data o_y,
    output thc_pkg::t_data o_z,
    output logic [SW-1:0]  o_side
);
    import thc_pkg::*;

    logic          r_v    [0:STAGES];
    logic          r_zero [0:STAGES];
    t_data         r_x    [0:STAGES];
    t_data         r_y    [0:STAGES];
    t_data         r_z    [0:STAGES];
    logic [SW-1:0] r_side [0:STAGES];

    t_data n_x, n_y, n_z;
    logic  n_zero;

    // Pre-rotation into the right half plane or into the +-90 degree range.
    always_comb begin
        n_x    = i_x;
        n_y    = i_y;
        n_z    = i_z;
        n_zero = 1'b0;
        if (VEC) begin
            n_zero = (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                n_x = -i_x;
                n_y = -i_y;
                n_z = (i_y >= 0) ? i_z + ANG_HALF : i_z - ANG_HALF;
            end
        end else begin
            if (i_z > ANG_QUARTER) begin
                n_x = -i_x;
                n_y = -i_y;
                n_z = i_z - ANG_HALF;
            end else if (i_z < -ANG_QUARTER) begin
                n_x = -i_x;
                n_y = -i_y;
                n_z = i_z + ANG_HALF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_x[0]    <= n_x;
        r_y[0]    <= n_y;
        r_z[0]    <= n_z;
        r_zero[0] <= n_zero;
        r_side[0] <= i_side;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_iter
        t_data xs, ys;
        logic  up;
        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign up = VEC ? (r_y[i] > 0) : (r_z[i] < 0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i+1] <= 1'b0;
            end else begin
                r_v[i+1] <= r_v[i];
            end
            if (up) begin
                r_x[i+1] <= r_x[i] + ys;
                r_y[i+1] <= r_y[i] - xs;
                r_z[i+1] <= r_z[i] + atan_tab(i);
            end else begin
                r_x[i+1] <= r_x[i] - ys;
                r_y[i+1] <= r_y[i] + xs;
                r_z[i+1] <= r_z[i] - atan_tab(i);
            end
            r_zero[i+1] <= r_zero[i];
            r_side[i+1] <= r_side[i];
        end
    end

    // A zero input vector gives angle and magnitude of zero.
    assign o_valid = r_v[STAGES];
    assign o_x     = r_zero[STAGES] ? '0 : r_x[STAGES];
    assign o_y     = r_y[STAGES];
    assign o_z     = r_zero[STAGES] ? '0 : r_z[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

@@ sv/thc_ungain.sv @@
// Two-stage removal of the CORDIC gain by a Q30 multiply split into partial products.
module thc_ungain #(
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  thc_pkg::t_data [LANES-1:0] i_v,
    input  logic [SW-1:0]              i_side,
    output logic                       o_valid,
    output thc_pkg::t_data [LANES-1:0] o_v,
    output logic [SW-1:0]              o_side
);
    import thc_pkg::*;

    localparam int LO = 17;
    localparam int HW = DW - LO;

    logic                     r_v1, r_v2;
    logic [SW-1:0]            r_side1, r_side2;
    logic signed [HW+30:0]    r_phi [LANES];
    logic signed [LO+31:0]    r_plo [LANES];
    t_data [LANES-1:0]        r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_side1 <= i_side;
        r_side2 <= r_side1;
    end

    for (genvar k = 0; k < LANES; k++) begin : g_lane
        logic signed [HW-1:0]   hi;
        logic signed [LO:0]     lo;
        logic signed [DW+31:0]  n_sum;
        assign hi    = $signed(i_v[k][DW-1:LO]);
        assign lo    = $signed({1'b0, i_v[k][LO-1:0]});
        assign n_sum = $signed({r_phi[k][HW+30], r_phi[k], {LO{1'b0}}})
                     + $signed({{(DW-LO){1'b0}}, r_plo[k]});

        always_ff @(posedge i_clk) begin
            r_phi[k] <= hi * INV_GAIN;
            r_plo[k] <= lo * INV_GAIN;
            r_out[k] <= n_sum[DW+29:30];
        end
    end

    assign o_valid = r_v2;
    assign o_v     = r_out;
    assign o_side  = r_side2;

endmodule

@@ sv/thc_finish.sv @@
// Conversion of binary angles to hundredths, declination, wrap and tilt clamp.
module thc_finish (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  thc_pkg::t_data i_head,
    input  thc_pkg::t_data i_pitch,
    input  logic [15:0]    i_decl,
    output logic           o_valid,
    output logic [15:0]    o_heading,
    output logic [13:0]    o_tilt
);
    import thc_pkg::*;

    localparam int PW = DW + 17;

    logic signed [PW-1:0] n_ph, n_pt;
    logic signed [20:0]   r_hd, r_tl;
    logic                 r_v1, r_v2;
    logic signed [21:0]   s0, s1, s2, s3, s4;
    logic signed [20:0]   t_abs;
    logic [15:0]          r_heading;
    logic [13:0]          r_tilt;

    // Rounded to nearest: floor((a * 36000 + 2^31) / 2^32).
    assign n_ph = i_head  * $signed(17'sd36000) + $signed(PW'(64'sd2147483648));
    assign n_pt = i_pitch * $signed(17'sd36000) + $signed(PW'(64'sd2147483648));

    always_comb begin
        s0 = 22'(r_hd) + 22'($signed(i_decl));
        s1 = (s0 < 0) ? s0 + 22'sd36000 : s0;
        s2 = (s1 < 0) ? s1 + 22'sd36000 : s1;
        s3 = (s2 >= 22'sd36000) ? s2 - 22'sd36000 : s2;
        s4 = (s3 >= 22'sd36000) ? s3 - 22'sd36000 : s3;
        t_abs = (r_tl < 0) ? -r_tl : r_tl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_hd      <= n_ph[PW-1:32];
        r_tl      <= n_pt[PW-1:32];
        r_heading <= s4[15:0];
        r_tilt    <= (t_abs > 21'sd9000) ? 14'd9000 : t_abs[13:0];
    end

    assign o_valid   = r_v2;
    assign o_heading = r_heading;
    assign o_tilt    = r_tilt;

endmodule

@@ sv/tilt_compensated_heading_top.sv @@
// Top level of the pipelined tilt-compensated compass heading block.
//
// One accelerometer sample and one magnetometer sample enter as an item when
// start is high and busy is low. Busy is never raised, so an item can be
// given in every clock cycle and the block sustains one item per cycle.
// Each item yields one result: o_heading (0 to 35999 hundredths of a degree,
// declination included) and o_tilt (absolute pitch, 0 to 9000 hundredths).
// The result is shown for exactly one cycle, marked by o_valid, and results
// leave in the order in which the items came in.
// An item passes an input register, five CORDIC passes in series (roll,
// pitch, two rotations and the final heading), each one register per
// iteration plus a pre-rotation register, three two-stage gain multipliers
// and two output stages.
// The declination register is written by i_declination_we and is to be
// changed only while no item is in flight.
// A synchronous reset clears every valid bit in the pipeline and sets the
// declination to zero; items in flight at reset are dropped.
// The receiver cannot stall, so there is no back-pressure anywhere inside.
module tilt_compensated_heading_top #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_accel_x,
    input  logic [11:0] i_accel_y,
    input  logic [11:0] i_accel_z,
    input  logic [15:0] i_mag_x,
    input  logic [15:0] i_mag_y,
    input  logic [15:0] i_mag_z,
    input  logic        i_declination_we,
    input  logic [15:0] i_declination,
    output logic        o_valid,
    output logic [15:0] o_heading,
    output logic [13:0] o_tilt
);
    import thc_pkg::*;

    localparam int LAT = 5 * CORDIC_STAGES + 14;

    logic [15:0] r_decl;
    logic        r_in_v;
    logic [11:0] r_ax, r_ay, r_az;
    logic [15:0] r_mx, r_my, r_mz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decl <= '0;
            r_in_v <= 1'b0;
        end else begin
            if (i_declination_we) begin
                r_decl <= i_declination;
            end
            r_in_v <= start && !busy;
        end
        r_ax <= i_accel_x;
        r_ay <= i_accel_y;
        r_az <= i_accel_z;
        r_mx <= i_mag_x;
        r_my <= i_mag_y;
        r_mz <= i_mag_z;
    end

    assign busy = 1'b0;

    // Roll: vector (az, ay) to get the roll angle and the magnitude.
    logic        c1_v;
    t_data       c1_x, c1_z;
    logic [59:0] c1_s;

    thc_cordic #(.STAGES(CORDIC_STAGES), .SW(60), .VEC(1'b1)) u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_in_v),
        .i_x(t_data'($signed({r_az, 16'h0}))),
        .i_y(t_data'($signed({r_ay, 16'h0}))),
        .i_z('0), .i_side({r_ax, r_mx, r_my, r_mz}),
        .o_valid(c1_v), .o_x(c1_x), .o_y(), .o_z(c1_z), .o_side(c1_s)
    );

    logic             u1_v;
    t_data [0:0]      u1_o;
    logic [95:0]      u1_s;

    thc_ungain #(.LANES(1), .SW(96)) u_ug_mag (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c1_v), .i_v(c1_x),
        .i_side({c1_z, c1_s}), .o_valid(u1_v), .o_v(u1_o), .o_side(u1_s)
    );

    // Pitch: vector (|a_yz|, -ax).
    logic        c2_v;
    t_data       c2_z;
    logic [83:0] c2_s;
    t_data       ax_neg;

    assign ax_neg = -t_data'($signed({u1_s[59:48], 16'h0}));

    thc_cordic #(.STAGES(CORDIC_STAGES), .SW(84), .VEC(1'b1)) u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(u1_v),
        .i_x(u1_o[0]), .i_y(ax_neg), .i_z('0),
        .i_side({u1_s[95:60], u1_s[47:0]}),
        .o_valid(c2_v), .o_x(), .o_y(), .o_z(c2_z), .o_side(c2_s)
    );

    // Rotate (mx, mz) by minus pitch.
    logic        c3_v;
    t_data       c3_x, c3_y;
    logic [87:0] c3_s;

    thc_cordic #(.STAGES(CORDIC_STAGES), .SW(88), .VEC(1'b0)) u_rot_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c2_v),
        .i_x(t_data'($signed({c2_s[47:32], 14'h0}))),
        .i_y(t_data'($signed({c2_s[15:0], 14'h0}))),
        .i_z(-c2_z), .i_side({c2_s[83:48], c2_s[31:16], c2_z}),
        .o_valid(c3_v), .o_x(c3_x), .o_y(c3_y), .o_z(), .o_side(c3_s)
    );

    logic        u2_v;
    t_data [1:0] u2_o;
    logic [87:0] u2_s;

    thc_ungain #(.LANES(2), .SW(88)) u_ug_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c3_v), .i_v({c3_y, c3_x}),
        .i_side(c3_s), .o_valid(u2_v), .o_v(u2_o), .o_side(u2_s)
    );

    // Rotate (my, w) by minus roll, where w is the negated second component.
    logic        c4_v;
    t_data       c4_x;
    logic [71:0] c4_s;

    thc_cordic #(.STAGES(CORDIC_STAGES), .SW(72), .VEC(1'b0)) u_rot_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(u2_v),
        .i_x(t_data'($signed({u2_s[51:36], 14'h0}))),
        .i_y(-u2_o[1]), .i_z(-t_data'(u2_s[87:52])),
        .i_side({u2_o[0], u2_s[35:0]}),
        .o_valid(c4_v), .o_x(c4_x), .o_y(), .o_z(), .o_side(c4_s)
    );

    logic        u3_v;
    t_data [0:0] u3_o;
    logic [71:0] u3_s;

    thc_ungain #(.LANES(1), .SW(72)) u_ug_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c4_v), .i_v(c4_x),
        .i_side(c4_s), .o_valid(u3_v), .o_v(u3_o), .o_side(u3_s)
    );

    // Heading: vector (Xh, Yh).
    logic        c5_v;
    t_data       c5_z;
    logic [35:0] c5_s;

    thc_cordic #(.STAGES(CORDIC_STAGES), .SW(36), .VEC(1'b1)) u_head (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(u3_v),
        .i_x(t_data'(u3_s[71:36])), .i_y(u3_o[0]), .i_z('0),
        .i_side(u3_s[35:0]),
        .o_valid(c5_v), .o_x(), .o_y(), .o_z(c5_z), .o_side(c5_s)
    );

    thc_finish u_finish (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(c5_v),
        .i_head(c5_z), .i_pitch(t_data'(c5_s)), .i_decl(r_decl),
        .o_valid(o_valid), .o_heading(o_heading), .o_tilt(o_tilt)
    );

    `include "tilt_compensated_heading_top_macros.svh"

    `THC_ASSERT_IMP(a_heading_range, i_clk, i_rst_n, o_valid, o_heading < 16'd36000)
    `THC_ASSERT_IMP(a_tilt_range, i_clk, i_rst_n, o_valid, o_tilt <= 14'd9000)
    `THC_ASSERT_DLY(a_latency, i_clk, i_rst_n, start && !busy, LAT, o_valid)

endmodule
